// ===== sv/tcx_pkg.sv =====
// Shared types, constants and helper functions of the tiny processor step core.
package tcx_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned MemAw    = $clog2(MemWords);
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned PcW      = 12;
  localparam int unsigned WordW    = 32;
  localparam int unsigned PcMask   = 32'h0000_0FFF;

  localparam logic [1:0] CmdWrMem = 2'd0;
  localparam logic [1:0] CmdWrReg = 2'd1;
  localparam logic [1:0] CmdStep  = 2'd2;
  localparam logic [1:0] CmdRdReg = 2'd3;

  localparam logic [7:0] OpAdd   = 8'd1;
  localparam logic [7:0] OpHalt  = 8'd2;
  localparam logic [7:0] OpJump  = 8'd3;
  localparam logic [7:0] OpLoad  = 8'd4;
  localparam logic [7:0] OpStore = 8'd5;
  localparam logic [7:0] OpBeq   = 8'd6;
  localparam logic [7:0] OpSub   = 8'd7;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StHalted = 3'd1,
    StOpcode = 3'd2,
    StAddr   = 3'd3,
    StReg    = 3'd4
  } status_e;

  typedef struct packed {
    logic             we;
    logic [RegAw-1:0] waddr;
    logic [WordW-1:0] wdata;
    logic             re;
    logic [RegAw-1:0] raddr_a;
    logic [RegAw-1:0] raddr_b;
    logic [RegAw-1:0] raddr_d;
  } rf_req_t;

  typedef struct packed {
    logic [WordW-1:0] rdata_a;
    logic [WordW-1:0] rdata_b;
    logic [WordW-1:0] rdata_d;
  } rf_rsp_t;

  function automatic logic mem_in_range(logic [WordW-1:0] addr);
    return addr < WordW'(MemWords);
  endfunction

  function automatic logic target_ok(logic [WordW-1:0] addr);
    return (addr < WordW'(MemWords)) && (addr <= WordW'(PcMask));
  endfunction

  function automatic logic reg_in_range(logic [7:0] idx);
    return WordW'(idx) < WordW'(NumRegs);
  endfunction

endpackage

// ===== sv/tcx_ram.sv =====
// Generic synchronous RAM: one write port, one read port with registered data.
module tcx_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/tcx_regfile.sv =====
// Register file: three RAM copies for three read ports, valid bits for the zero reset.
module tcx_regfile import tcx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rf_req_t req_i,
  output rf_rsp_t rsp_o
);

  logic [NumRegs-1:0] vld_q;
  logic               vld_a_q, vld_b_q, vld_d_q;
  logic [WordW-1:0]   ram_a, ram_b, ram_d;

  tcx_ram #(.Depth(NumRegs), .Width(WordW)) u_ram_a (
    .clk_i, .we_i(req_i.we), .waddr_i(req_i.waddr), .wdata_i(req_i.wdata),
    .re_i(req_i.re), .raddr_i(req_i.raddr_a), .rdata_o(ram_a)
  );

  tcx_ram #(.Depth(NumRegs), .Width(WordW)) u_ram_b (
    .clk_i, .we_i(req_i.we), .waddr_i(req_i.waddr), .wdata_i(req_i.wdata),
    .re_i(req_i.re), .raddr_i(req_i.raddr_b), .rdata_o(ram_b)
  );

  tcx_ram #(.Depth(NumRegs), .Width(WordW)) u_ram_d (
    .clk_i, .we_i(req_i.we), .waddr_i(req_i.waddr), .wdata_i(req_i.wdata),
    .re_i(req_i.re), .raddr_i(req_i.raddr_d), .rdata_o(ram_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        vld_a_q <= vld_q[req_i.raddr_a];
        vld_b_q <= vld_q[req_i.raddr_b];
        vld_d_q <= vld_q[req_i.raddr_d];
      end
    end
  end

  assign rsp_o.rdata_a = vld_a_q ? ram_a : '0;
  assign rsp_o.rdata_b = vld_b_q ? ram_b : '0;
  assign rsp_o.rdata_d = vld_d_q ? ram_d : '0;

endmodule

// ===== sv/tiny_cpu_execute_step_core.sv =====
// Top level of the tiny processor step core: command sequencer, word memory and register file.
//
// Input stream (s_axis): one beat is one command. tuser carries the command
// (write memory word, write register, execute one step, read register), tdata
// carries the target index and the write value. Output stream (m_axis): one
// beat per command with status, read value, next pc, halted flag and opcode.
// The APB port holds the entry address; writing it also loads the pc.
//
// Sequencing after a command is accepted: a memory or register write finishes in
// the issue state, a register read in the register-read state, and a step passes
// fetch, register file read and execute, with a load adding a memory read; a
// halt or an opcode or register-index fault ends a step in the decode state, a
// bad index or a halted core in the issue state. The next command is accepted at
// the edge that loads the output register, so commands are taken one at a time.
//
// Reset clears the pc, the entry address, the halted flag and all registers
// to zero; the word memory holds garbage until written. When the receiver
// stalls, the result waits in the output register; a finished command waits in
// its last state and no further command is taken until the result can move.
module tiny_cpu_execute_step_core import tcx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] target_index, [43:12] write_value, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [34:3] read_value, [46:35] next_pc, [47] halted,
  // [55:48] executed_opcode
  output logic [55:0] m_axis_tdata
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SIssue  = 3'd1;
  localparam logic [2:0] SDecode = 3'd2;
  localparam logic [2:0] SExec   = 3'd3;
  localparam logic [2:0] SLoad   = 3'd4;
  localparam logic [2:0] SRdReg  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [1:0]       cmd_q;
  logic [11:0]      idx_q;
  logic [WordW-1:0] val_q;
  logic [PcW-1:0]   pc_q, pc_d;
  logic [PcW-1:0]   entry_q;
  logic             halted_q, halted_d;
  logic [7:0]       opc_q;
  logic [RegAw-1:0] dst_q;
  logic             out_valid_q;
  logic [55:0]      out_data_q;

  logic             accept, done, out_free, commit, cfg_wr;
  status_e          res_status;
  logic [WordW-1:0] res_rv;
  logic [7:0]       res_opc;

  logic             mem_we_c, mem_re;
  logic [MemAw-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;
  logic             rf_we_c;
  rf_req_t          rf_req;
  rf_rsp_t          rf_rsp;

  logic [7:0]       f_opc, f_dst, f_src1, f_src2;
  logic [WordW-1:0] op_a, op_b, op_d;

  assign f_opc  = mem_rdata[31:24];
  assign f_dst  = mem_rdata[23:16];
  assign f_src1 = mem_rdata[15:8];
  assign f_src2 = mem_rdata[7:0];
  assign op_a   = rf_rsp.rdata_a;
  assign op_b   = rf_rsp.rdata_b;
  assign op_d   = rf_rsp.rdata_d;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = done && out_free;
  assign s_axis_tready = (state_q == SIdle) || commit;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = 32'(entry_q);

  tcx_ram #(.Depth(MemWords), .Width(WordW)) u_mem (
    .clk_i,
    .we_i   (mem_we_c && commit),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  tcx_regfile u_rf (
    .clk_i,
    .rst_ni,
    .req_i(rf_req),
    .rsp_o(rf_rsp)
  );

  always_comb begin
    done           = 1'b0;
    res_status     = StOk;
    res_rv         = '0;
    res_opc        = '0;
    pc_d           = pc_q;
    halted_d       = halted_q;
    state_d        = state_q;
    mem_we_c       = 1'b0;
    mem_waddr      = MemAw'(idx_q);
    mem_wdata      = val_q;
    mem_re         = 1'b0;
    mem_raddr      = MemAw'(pc_q);
    rf_we_c        = 1'b0;
    rf_req.waddr   = RegAw'(idx_q);
    rf_req.wdata   = val_q;
    rf_req.re      = 1'b0;
    rf_req.raddr_a = RegAw'(idx_q);
    rf_req.raddr_b = RegAw'(f_src2);
    rf_req.raddr_d = RegAw'(f_dst);

    case (state_q)
      SIssue: begin
        case (cmd_q)
          CmdWrMem: begin
            done = 1'b1;
            if (mem_in_range(32'(idx_q))) begin
              mem_we_c = 1'b1;
            end else begin
              res_status = StAddr;
            end
          end
          CmdWrReg: begin
            done = 1'b1;
            if (reg_in_range(8'(idx_q)) && idx_q[11:8] == 4'd0) begin
              rf_we_c = 1'b1;
            end else begin
              res_status = StReg;
            end
          end
          CmdRdReg: begin
            if (reg_in_range(8'(idx_q)) && idx_q[11:8] == 4'd0) begin
              rf_req.re = 1'b1;
              state_d   = SRdReg;
            end else begin
              done       = 1'b1;
              res_status = StReg;
            end
          end
          default: begin
            if (halted_q) begin
              done       = 1'b1;
              res_status = StHalted;
            end else if (!mem_in_range(32'(pc_q))) begin
              done       = 1'b1;
              res_status = StAddr;
            end else begin
              mem_re  = 1'b1;
              state_d = SDecode;
            end
          end
        endcase
      end
      SDecode: begin
        res_opc        = f_opc;
        rf_req.raddr_a = RegAw'(f_src1);
        if (!(f_opc inside {[OpAdd:OpSub]})) begin
          done       = 1'b1;
          res_status = StOpcode;
        end else if (f_opc == OpHalt) begin
          done     = 1'b1;
          halted_d = 1'b1;
        end else if (!reg_in_range(f_dst) ||
                     (f_opc != OpJump && !reg_in_range(f_src1)) ||
                     ((f_opc inside {OpAdd, OpSub, OpBeq}) && !reg_in_range(f_src2))) begin
          done       = 1'b1;
          res_status = StReg;
        end else begin
          rf_req.re = 1'b1;
          state_d   = SExec;
        end
      end
      SExec: begin
        res_opc      = opc_q;
        rf_req.waddr = dst_q;
        case (opc_q)
          OpAdd, OpSub: begin
            done         = 1'b1;
            res_rv       = (opc_q == OpAdd) ? op_a + op_b : op_a - op_b;
            rf_we_c      = 1'b1;
            rf_req.wdata = res_rv;
            pc_d         = pc_q + PcW'(1);
          end
          OpJump: begin
            done = 1'b1;
            if (target_ok(op_d)) begin
              pc_d = op_d[PcW-1:0];
            end else begin
              res_status = StAddr;
            end
          end
          OpLoad, OpStore: begin
            mem_waddr = MemAw'(op_a);
            mem_wdata = op_d;
            mem_raddr = MemAw'(op_a);
            if (!mem_in_range(op_a)) begin
              done       = 1'b1;
              res_status = StAddr;
            end else if (opc_q == OpStore) begin
              done     = 1'b1;
              mem_we_c = 1'b1;
              pc_d     = pc_q + PcW'(1);
            end else begin
              mem_re  = 1'b1;
              state_d = SLoad;
            end
          end
          OpBeq: begin
            done = 1'b1;
            if (op_a == op_b) begin
              if (target_ok(op_d)) begin
                pc_d = op_d[PcW-1:0];
              end else begin
                res_status = StAddr;
              end
            end else begin
              pc_d = pc_q + PcW'(1);
            end
          end
          default: begin
            done       = 1'b1;
            res_status = StOpcode;
          end
        endcase
      end
      SLoad: begin
        done         = 1'b1;
        res_opc      = opc_q;
        res_rv       = mem_rdata;
        rf_we_c      = 1'b1;
        rf_req.waddr = dst_q;
        rf_req.wdata = mem_rdata;
        pc_d         = pc_q + PcW'(1);
      end
      SRdReg: begin
        done   = 1'b1;
        res_rv = op_a;
      end
      default: ;
    endcase

    rf_req.we = rf_we_c && commit;

    if (done) begin
      if (commit) begin
        state_d = accept ? SIssue : SIdle;
      end else begin
        state_d = state_q;
      end
    end else if (state_q == SIdle && accept) begin
      state_d = SIssue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pc_q        <= '0;
      entry_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && !paddr[2]) begin
        entry_q <= pwdata[PcW-1:0];
        pc_q    <= pwdata[PcW-1:0];
      end else if (commit) begin
        pc_q <= pc_d;
      end
      if (commit) begin
        halted_q    <= halted_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser;
      idx_q <= s_axis_tdata[11:0];
      val_q <= s_axis_tdata[43:12];
    end
    if (state_q == SDecode) begin
      opc_q <= f_opc;
      dst_q <= RegAw'(f_dst);
    end
    if (commit) begin
      out_data_q <= {res_opc, halted_d, pc_d, res_rv, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/tcx_checker.sv =====
// Port-level checker of the tiny processor step core and its bind.
module tcx_checker import tcx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic [2:0] st;
  logic [7:0] opc;

  assign st  = m_axis_tdata[2:0];
  assign opc = m_axis_tdata[55:48];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> st <= StReg)
    else $error("status code out of range");

  a_halted_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == StHalted |->
      opc == 8'd0 && m_axis_tdata[34:3] == '0 && m_axis_tdata[47])
    else $error("halted status with fetched opcode, data or clear flag");

  a_bad_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == StOpcode |-> opc == 8'd0 || opc > OpSub)
    else $error("opcode fault on a known opcode");

endmodule

bind tiny_cpu_execute_step_core tcx_checker u_tcx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
